/* src/wsd_pkg.sv */
package wsd_pkg;

   // Result status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_FIRST  = 2'd1;
   localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;

   // Header constants
   localparam logic [3:0] FIRST_NIBBLE = 4'h8;  // FIN set, RSV clear
   localparam logic [3:0] ERR_OPCODE   = 4'hF;
   localparam logic [6:0] LEN_EXT16    = 7'd126;
   localparam logic [6:0] LEN_EXT64    = 7'd127;

   // Extended length and mask key sizes in bytes
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   // Widths of the result channel
   localparam int RSP_DATA_W = 80;

   // One classified byte, passed from the parser to the output stage
   typedef struct packed {
      logic [7:0]  raw_byte;        // received byte, still masked
      logic [7:0]  key_byte;        // mask key byte for this position
      logic        byte_valid;
      logic        frame_done;
      logic [1:0]  status;
      logic [3:0]  opcode;
      logic [3:0]  header_length;
      logic [63:0] payload_length;
   } wsd_entry_type;

endpackage

/* src/wsd_front.sv */
module wsd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] data_byte
   input  logic                   req_tlast,   // buffer_end
   input  logic                   q_full,
   output logic                   push_valid,
   output wsd_pkg::wsd_entry_type push_entry
);
   import wsd_pkg::*;

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_SECOND,
      PH_EXTLEN,
      PH_MASK,
      PH_PAYLOAD,
      PH_SKIP
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        mask_ff, mask_in;
   logic [3:0]  index_ff, index_in;
   logic [63:0] length_ff, length_in;
   logic [31:0] key_ff, key_in;
   logic [63:0] remain_ff, remain_in;
   logic [1:0]  lane_ff, lane_in;
   logic [3:0]  hdr_len_ff, hdr_len_in;

   logic        accept;
   logic        length_done;
   logic        key_done;
   logic        finish;
   logic [7:0]  b;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;

   // Header parse and payload classification, one byte per transfer
   always_comb begin
      phase_in    = phase_ff;
      opcode_in   = opcode_ff;
      mask_in     = mask_ff;
      index_in    = index_ff;
      length_in   = length_ff;
      key_in      = key_ff;
      remain_in   = remain_ff;
      lane_in     = lane_ff;
      hdr_len_in  = hdr_len_ff;
      length_done = 1'b0;
      key_done    = 1'b0;
      finish      = 1'b0;
      push_valid  = 1'b0;
      push_entry  = '0;

      if (accept) begin
         unique case (phase_ff)
            PH_FIRST: begin
               if (req_tlast) begin
                  push_valid            = 1'b1;
                  push_entry.frame_done = 1'b1;
                  push_entry.status     = STATUS_INCOMPLETE;
                  push_entry.opcode     = ERR_OPCODE;
               end else if (b[7:4] != FIRST_NIBBLE) begin
                  push_valid            = 1'b1;
                  push_entry.frame_done = 1'b1;
                  push_entry.status     = STATUS_BAD_FIRST;
                  push_entry.opcode     = ERR_OPCODE;
                  phase_in              = PH_SKIP;
               end else begin
                  opcode_in  = b[3:0];
                  mask_in    = 1'b0;
                  key_in     = '0;
                  length_in  = '0;
                  index_in   = '0;
                  hdr_len_in = 4'd1;
                  phase_in   = PH_SECOND;
               end
            end
            PH_SECOND: begin
               hdr_len_in = 4'd2;
               mask_in    = b[7];
               length_in  = '0;
               if (b[6:0] == LEN_EXT16) begin
                  index_in = EXT16_BYTES;
                  phase_in = PH_EXTLEN;
               end else if (b[6:0] == LEN_EXT64) begin
                  index_in = EXT64_BYTES;
                  phase_in = PH_EXTLEN;
               end else begin
                  length_in   = {57'd0, b[6:0]};
                  length_done = 1'b1;
               end
            end
            PH_EXTLEN: begin
               length_in  = {length_ff[55:0], b};
               hdr_len_in = 4'(hdr_len_ff + 4'd1);
               index_in   = 4'(index_ff - 4'd1);
               length_done = (index_in == 4'd0);
            end
            PH_MASK: begin
               key_in     = {key_ff[23:0], b};
               hdr_len_in = 4'(hdr_len_ff + 4'd1);
               index_in   = 4'(index_ff - 4'd1);
               key_done   = (index_in == 4'd0);
            end
            PH_PAYLOAD: begin
               push_valid            = 1'b1;
               push_entry.byte_valid = 1'b1;
               push_entry.raw_byte   = b;
               unique case (lane_ff)
                  2'd0:    push_entry.key_byte = key_ff[31:24];
                  2'd1:    push_entry.key_byte = key_ff[23:16];
                  2'd2:    push_entry.key_byte = key_ff[15:8];
                  default: push_entry.key_byte = key_ff[7:0];
               endcase
               lane_in   = 2'(lane_ff + 2'd1);
               remain_in = 64'(remain_ff - 64'd1);
               finish    = (remain_ff == 64'd1);
            end
            default: begin
               // skip trailing bytes until the buffer ends
               if (req_tlast) begin
                  phase_in = PH_FIRST;
               end
            end
         endcase

         // length known: mask key next, or straight to payload
         if (length_done) begin
            if (mask_in) begin
               phase_in = PH_MASK;
               index_in = KEY_BYTES;
            end else begin
               key_done = 1'b1;
            end
         end

         // header complete: start payload or finish an empty frame
         if (key_done) begin
            lane_in   = '0;
            remain_in = length_in;
            if (length_in == 64'd0) begin
               finish = 1'b1;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end

         if (finish) begin
            push_valid            = 1'b1;
            push_entry.frame_done = 1'b1;
            push_entry.status     = STATUS_OK;
            push_entry.opcode     = opcode_ff;
            phase_in              = PH_SKIP;
         end

         // buffer ran out inside a frame
         if (req_tlast && (phase_ff == PH_SECOND || phase_ff == PH_EXTLEN ||
                           phase_ff == PH_MASK || phase_ff == PH_PAYLOAD)) begin
            phase_in = PH_FIRST;
            if (!finish) begin
               push_valid            = 1'b1;
               push_entry.frame_done = 1'b1;
               push_entry.status     = STATUS_INCOMPLETE;
               push_entry.opcode     = ERR_OPCODE;
            end
         end

         push_entry.header_length  = hdr_len_in;
         push_entry.payload_length = length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_FIRST;
         opcode_ff  <= '0;
         mask_ff    <= 1'b0;
         index_ff   <= '0;
         length_ff  <= '0;
         key_ff     <= '0;
         remain_ff  <= '0;
         lane_ff    <= '0;
         hdr_len_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         opcode_ff  <= opcode_in;
         mask_ff    <= mask_in;
         index_ff   <= index_in;
         length_ff  <= length_in;
         key_ff     <= key_in;
         remain_ff  <= remain_in;
         lane_ff    <= lane_in;
         hdr_len_ff <= hdr_len_in;
      end
   end

endmodule

/* src/wsd_queue.sv */
module wsd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  wsd_pkg::wsd_entry_type push_entry,
   output logic                   q_full,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output wsd_pkg::wsd_entry_type pop_entry
);
   import wsd_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   wsd_entry_type mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign q_full    = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = mem[rd_ptr_ff];
   assign do_push   = push_valid && !q_full;
   assign do_pop    = pop_valid && pop_ready;

   // Pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* src/wsd_back.sv */
module wsd_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 pop_valid,
   output logic                                 pop_ready,
   input  wsd_pkg::wsd_entry_type               pop_entry,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [wsd_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast
);
   import wsd_pkg::*;

   logic                  valid_ff;
   logic [RSP_DATA_W-1:0] data_ff, data_in;
   logic                  user_ff, user_in;
   logic                  last_ff, last_in;
   logic [7:0]            payload;
   logic [63:0]           consumed;

   assign pop_ready = !valid_ff || rsp_tready;

   // Unmask payload and total the consumed byte count
   always_comb begin
      payload  = pop_entry.byte_valid ? (pop_entry.raw_byte ^ pop_entry.key_byte) : 8'd0;
      consumed = '0;
      if (pop_entry.frame_done && pop_entry.status == STATUS_OK) begin
         consumed = {60'd0, pop_entry.header_length} + pop_entry.payload_length;
      end
      data_in = {2'b00, consumed, pop_entry.status, pop_entry.opcode, payload};
      user_in = pop_entry.byte_valid;
      last_in = pop_entry.frame_done;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop_ready) begin
         valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) begin
         data_ff <= data_in;
         user_ff <= user_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

/* src/websocket_frame_deframer.sv */
// WebSocket frame deframer.
// The req channel carries one received byte per transfer, with req_tlast on
// the last byte of the buffer. The block parses one frame header (first
// byte, length byte, 16- or 64-bit extended length, optional mask key) and
// sends each payload byte, unmasked, on the rsp channel (rsp_tuser high).
// The result with rsp_tlast high closes the frame run and carries status,
// opcode and consumed count; on an incomplete status the payload already
// sent is to be dropped. Bytes after the frame produce no result until the
// buffer ends, then the next buffer starts a new frame.
// Throughput: one byte per cycle while the queue is not full; a stalled rsp
// can hold req_tready low. Each result passes through the entry queue and
// then the output register before rsp_tvalid rises.
// The parser classifies each byte combinationally in the transfer cycle; the
// 64-bit consumed sum is formed in the output stage.
// Reset: synchronous; the parser waits for a first header byte and the
// queue and output register are empty. No clearing pass is needed.
// Backpressure: a stalled rsp fills the QUEUE_DEPTH-entry queue, after
// which req_tready drops until an entry drains. QUEUE_DEPTH must be >= 2.
module websocket_frame_deframer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] data_byte
   input  logic                               req_tlast,   // buffer_end
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] payload_byte, [11:8] frame_opcode, [13:12] status,
   // [77:14] consumed, [79:78] zero
   output logic [wsd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser,   // byte_valid
   output logic                               rsp_tlast    // frame_done
);
   import wsd_pkg::*;

   wsd_entry_type push_entry;
   wsd_entry_type pop_entry;
   logic          push_valid;
   logic          q_full;
   logic          pop_valid;
   logic          pop_ready;

   wsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   wsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_full     (q_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   wsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // The parser never pushes into a full queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_full)
      else $error("entry pushed into full queue");

   // Results that do not close a frame carry no status, opcode or count
   a_mid_run_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |->
         (rsp_tdata[13:12] == STATUS_OK && rsp_tdata[11:8] == 4'd0 &&
          rsp_tdata[77:14] == 64'd0))
      else $error("status fields set on a result inside a frame");

   // Any error closes with the error opcode and no count
   a_error_opcode : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[13:12] != STATUS_OK) |->
         (rsp_tlast && rsp_tdata[11:8] == ERR_OPCODE && rsp_tdata[77:14] == 64'd0))
      else $error("error result without error opcode");

   // A non-payload result must have a zero payload byte
   a_idle_byte_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tlast && rsp_tdata[7:0] == 8'd0))
      else $error("stray payload byte");

endmodule

/* dv/websocket_frame_deframer_checker.sv */
`timescale 1ns / 100ps

// Watches both streams of the deframer, predicts each result from the bytes
// taken on req and compares the results seen on rsp in order.
module websocket_frame_deframer_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [7:0]                     req_tdata,
   input  logic                           req_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [wsd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           rsp_tuser,
   input  logic                           rsp_tlast,
   output int                             mismatch_count,
   output int                             pending_results,
   output int                             frames_ok,
   output int                             frames_bad,
   output int                             frames_cut,
   output int                             payload_bytes
);
   import wsd_pkg::*;

   typedef enum logic [2:0] {
      HDR_FIRST, HDR_LEN, HDR_EXTLEN, HDR_KEY, BODY, DRAIN
   } parse_phase_type;

   typedef struct packed {
      logic [7:0]  payload;
      logic        valid;
      logic [3:0]  opcode;
      logic        done;
      logic [1:0]  status;
      logic [63:0] consumed;
   } frame_result_type;

   // Parser state of the prediction
   parse_phase_type phase_q;
   logic [3:0]      opcode_q;
   logic            masked_q;
   logic [3:0]      bytes_left_q;
   logic [63:0]     length_q;
   logic [31:0]     key_q;
   logic [63:0]     count_q;
   logic [3:0]      header_len_q;

   frame_result_type results_due[$];
   int errors_seen;
   int ok_seen, bad_seen, cut_seen, bytes_seen;

   initial begin
      errors_seen     = 0;
      ok_seen         = 0;
      bad_seen        = 0;
      cut_seen        = 0;
      bytes_seen      = 0;
   end

   task automatic close_ok(inout frame_result_type r, input logic [63:0] total);
      r.done     = 1'b1;
      r.status   = STATUS_OK;
      r.opcode   = opcode_q;
      r.consumed = total;
      phase_q    = DRAIN;
   endtask

   task automatic open_body(inout frame_result_type r);
      count_q = '0;
      if (length_q == 64'd0) close_ok(r, 64'(header_len_q));
      else phase_q = BODY;
   endtask

   task automatic end_of_length(inout frame_result_type r);
      if (masked_q) begin
         phase_q      = HDR_KEY;
         bytes_left_q = KEY_BYTES;
      end else begin
         open_body(r);
      end
   endtask

   // One byte through the header parser; queues the result it causes, if any
   task automatic deframe_byte(input logic [7:0] b, input logic last);
      frame_result_type r;
      logic [6:0]       len7;
      r = '0;
      case (phase_q)
         HDR_FIRST: begin
            if (last) begin
               r.done   = 1'b1;
               r.status = STATUS_INCOMPLETE;
               r.opcode = ERR_OPCODE;
            end else if (b[7:4] != FIRST_NIBBLE) begin
               r.done   = 1'b1;
               r.status = STATUS_BAD_FIRST;
               r.opcode = ERR_OPCODE;
               phase_q  = DRAIN;
            end else begin
               opcode_q     = b[3:0];
               masked_q     = 1'b0;
               key_q        = '0;
               length_q     = '0;
               count_q      = '0;
               bytes_left_q = '0;
               header_len_q = 4'd1;
               phase_q      = HDR_LEN;
            end
         end
         HDR_LEN: begin
            header_len_q = 4'd2;
            masked_q     = b[7];
            len7         = b[6:0];
            length_q     = '0;
            if (len7 == LEN_EXT16) begin
               bytes_left_q = EXT16_BYTES;
               phase_q      = HDR_EXTLEN;
            end else if (len7 == LEN_EXT64) begin
               bytes_left_q = EXT64_BYTES;
               phase_q      = HDR_EXTLEN;
            end else begin
               length_q = 64'(len7);
               end_of_length(r);
            end
         end
         HDR_EXTLEN: begin
            length_q     = {length_q[55:0], b};
            header_len_q = header_len_q + 4'd1;
            bytes_left_q = bytes_left_q - 4'd1;
            if (bytes_left_q == 4'd0) end_of_length(r);
         end
         HDR_KEY: begin
            key_q        = {key_q[23:0], b};
            header_len_q = header_len_q + 4'd1;
            bytes_left_q = bytes_left_q - 4'd1;
            if (bytes_left_q == 4'd0) open_body(r);
         end
         BODY: begin
            // key byte 0 sits in the top bits of the key
            r.valid   = 1'b1;
            r.payload = b ^ key_q[8 * (3 - count_q[1:0]) +: 8];
            count_q   = count_q + 64'd1;
            if (count_q == length_q) close_ok(r, 64'(header_len_q) + length_q);
         end
         DRAIN: begin
            // trailing bytes are dropped; buffer end rearms silently
            if (last) phase_q = HDR_FIRST;
            return;
         end
         default: ;
      endcase

      // buffer end in the middle of a frame closes it as incomplete
      if (last && phase_q != HDR_FIRST) begin
         if (!r.done) begin
            r.done     = 1'b1;
            r.status   = STATUS_INCOMPLETE;
            r.opcode   = ERR_OPCODE;
            r.consumed = '0;
         end
         phase_q = HDR_FIRST;
      end

      if (r.valid) bytes_seen++;
      if (r.done) begin
         if (r.status == STATUS_OK) ok_seen++;
         else if (r.status == STATUS_BAD_FIRST) bad_seen++;
         else cut_seen++;
      end
      if (r.done || r.valid) results_due.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         errors_seen++;
      end
   endtask

   // Compare results first, then predict from the byte taken at this edge
   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         phase_q      = HDR_FIRST;
         opcode_q     = '0;
         masked_q     = 1'b0;
         bytes_left_q = '0;
         length_q     = '0;
         key_q        = '0;
         count_q      = '0;
         header_len_q = '0;
         results_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               $error("result with nothing expected: tdata %0h tuser %0b tlast %0b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               errors_seen++;
            end else begin
               want = results_due.pop_front();
               check_field("payload_byte", 64'(want.payload), 64'(rsp_tdata[7:0]));
               check_field("byte_valid", 64'(want.valid), 64'(rsp_tuser));
               check_field("frame_opcode", 64'(want.opcode), 64'(rsp_tdata[11:8]));
               check_field("frame_done", 64'(want.done), 64'(rsp_tlast));
               check_field("status", 64'(want.status), 64'(rsp_tdata[13:12]));
               check_field("consumed", want.consumed, rsp_tdata[77:14]);
            end
         end
         if (req_tvalid && req_tready) deframe_byte(req_tdata, req_tlast);
      end
      mismatch_count  <= errors_seen;
      pending_results <= results_due.size();
      frames_ok       <= ok_seen;
      frames_bad      <= bad_seen;
      frames_cut      <= cut_seen;
      payload_bytes   <= bytes_seen;
   end

endmodule

/* dv/tb_websocket_frame_deframer.sv */
`timescale 1ns / 100ps

// Byte stimulus for the deframer: a few hand-built buffers, then random
// frames (mostly well formed, some cut short, some noise) under four
// idle/stall mixes. The checker instance does all prediction.
module tb_websocket_frame_deframer;
   import wsd_pkg::*;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;  // [7:0] data_byte
   logic                  req_tlast  = 1'b0; // buffer_end
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [7:0] payload_byte, [11:8] frame_opcode, [13:12] status, [77:14] consumed
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;          // byte_valid
   logic                  rsp_tlast;          // frame_done

   int mismatch_count, pending_results;
   int frames_ok, frames_bad, frames_cut, payload_bytes;
   int bytes_sent         = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int idle_plan[4]  = '{0, 81, 0, 15};
   int stall_plan[4] = '{0, 0, 81, 15};

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   websocket_frame_deframer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   websocket_frame_deframer_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results),
      .frames_ok       (frames_ok),
      .frames_bad      (frames_bad),
      .frames_cut      (frames_cut),
      .payload_bytes   (payload_bytes)
   );

   // Receiver backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // One transfer on req; valid stays high into the next byte unless idling
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_buffer(input logic [7:0] buffer_q[$]);
      for (int i = 0; i < buffer_q.size(); i++)
         send_byte(buffer_q[i], i == buffer_q.size() - 1);
   endtask

   // Random buffer: a frame with random header and content, or plain noise
   task automatic send_random_buffer();
      logic [7:0]  frame_q[$];
      logic [63:0] plen;
      logic        masked;
      int          kind, n, cut;
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 6);
         repeat (n) frame_q.push_back(8'($urandom));
      end else begin
         frame_q.push_back({FIRST_NIBBLE, 4'($urandom)});
         masked = 1'($urandom);
         kind   = $urandom_range(0, 9);
         if (kind < 6) begin
            plen = 64'($urandom_range(0, ($urandom_range(0, 7) == 0) ? 125 : 12));
            frame_q.push_back({masked, plen[6:0]});
         end else if (kind < 8) begin
            plen = 64'($urandom_range(0, 300));
            frame_q.push_back({masked, LEN_EXT16});
            frame_q.push_back(plen[15:8]);
            frame_q.push_back(plen[7:0]);
         end else begin
            // occasionally a huge length that can only end cut short
            if ($urandom_range(0, 3) == 0) plen = {$urandom, $urandom};
            else plen = 64'($urandom_range(0, 40));
            frame_q.push_back({masked, LEN_EXT64});
            for (int i = 7; i >= 0; i--) frame_q.push_back(plen[8 * i +: 8]);
         end
         if (masked) repeat (4) frame_q.push_back(8'($urandom));
         n = (plen > 64'd300) ? $urandom_range(0, 8) : int'(plen);
         repeat (n) frame_q.push_back(8'($urandom));
         if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 3);
            repeat (n) frame_q.push_back(8'($urandom));
         end
      end
      // some buffers end early, anywhere in the frame
      if ($urandom_range(0, 7) == 0) begin
         cut     = $urandom_range(1, frame_q.size());
         frame_q = frame_q[0:cut-1];
      end
      send_buffer(frame_q);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed buffers
      send_buffer('{8'h81});                       // ends on the first byte
      send_buffer('{8'h7F, 8'h00, 8'hFF});         // bad first byte, then skipped
      send_buffer('{8'h80, 8'h00});                // empty payload, done on last byte
      send_buffer('{8'h8F, 8'h82, 8'hA5, 8'h5A, 8'hFF, 8'h00,
                    8'h12, 8'h34, 8'hEE});         // masked, trailing byte ignored
      send_buffer('{8'h81, 8'h7E, 8'h00, 8'h01, 8'hC3}); // 16-bit length
      send_buffer('{8'h82, 8'hFF, 8'h80});         // cut inside 64-bit length

      // Random phases with different idle and stall mixes
      for (int p = 0; p < 4; p++) begin
         sender_idle_pct    = idle_plan[p];
         receiver_stall_pct = stall_plan[p];
         while (bytes_sent < 25 + 250 * (p + 1)) send_random_buffer();
      end
      req_tvalid <= 1'b0;

      // Drain, then wait for any stray result
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("run covered %0d bytes: %0d frames ok, %0d bad first byte, %0d cut short",
               bytes_sent, frames_ok, frames_bad, frames_cut);
      $display("%0d payload bytes checked across four idle/stall mixes", payload_bytes);
      if (mismatch_count == 0) begin
         $display("tb_websocket_frame_deframer: done, clean");
      end else begin
         $display("tb_websocket_frame_deframer: done, errors");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("tb_websocket_frame_deframer: done, errors");
      $finish;
   end

endmodule
